// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Types, constants and the color rule chain of the color sensor conditioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  typedef struct packed {
    logic [15:0] red_pulse;
    logic [15:0] green_pulse;
    logic [15:0] blue_pulse;
  } csc_in_t;

  typedef struct packed {
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [15:0] packed_565;
    logic [4:0]  color_class;
    logic [4:0]  stable_class;
  } csc_out_t;

  // Pulse to level mapping: level = 255 - (x - 20) * 255 / 160.
  localparam logic [15:0] PULSE_OFS  = 16'd20;
  localparam logic [7:0]  LEVEL_TOP  = 8'd255;
  // Exact floor(x / 5) for x below 2^19 as (x * DIV5_MUL) >> DIV5_SHIFT.
  localparam logic [18:0] DIV5_MUL   = 19'd419431;
  localparam int          DIV5_SHIFT = 21;

  localparam logic [3:0]  THRESH_RESET = 4'd5;

  localparam logic [4:0] CLS_WHITE      = 5'd0;
  localparam logic [4:0] CLS_BLACK      = 5'd1;
  localparam logic [4:0] CLS_SILVER     = 5'd2;
  localparam logic [4:0] CLS_GRAY       = 5'd3;
  localparam logic [4:0] CLS_RED        = 5'd4;
  localparam logic [4:0] CLS_MAROON     = 5'd5;
  localparam logic [4:0] CLS_ORANGE     = 5'd6;
  localparam logic [4:0] CLS_GOLD       = 5'd7;
  localparam logic [4:0] CLS_YELLOW     = 5'd8;
  localparam logic [4:0] CLS_LIME       = 5'd9;
  localparam logic [4:0] CLS_GREEN      = 5'd10;
  localparam logic [4:0] CLS_DARK_GREEN = 5'd11;
  localparam logic [4:0] CLS_CYAN       = 5'd12;
  localparam logic [4:0] CLS_SKY_BLUE   = 5'd13;
  localparam logic [4:0] CLS_BLUE       = 5'd14;
  localparam logic [4:0] CLS_NAVY       = 5'd15;
  localparam logic [4:0] CLS_PURPLE     = 5'd16;
  localparam logic [4:0] CLS_VIOLET     = 5'd17;
  localparam logic [4:0] CLS_PINK       = 5'd18;
  localparam logic [4:0] CLS_BROWN      = 5'd19;
  localparam logic [4:0] CLS_CHOCOLATE  = 5'd20;
  localparam logic [4:0] CLS_BEIGE      = 5'd21;
  localparam logic [4:0] CLS_TAN        = 5'd22;
  localparam logic [4:0] CLS_OLIVE      = 5'd23;
  localparam logic [4:0] CLS_TEAL       = 5'd24;
  localparam logic [4:0] CLS_LAVENDER   = 5'd25;
  localparam logic [4:0] CLS_CORAL      = 5'd26;
  localparam logic [4:0] CLS_UNKNOWN    = 5'd27;

  // First matching rule wins.
  function automatic logic [4:0] classify(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [7:0] rg;
    logic [7:0] rb;
    logic       near;
    logic [4:0] cls;
    rg   = (r >= g) ? (r - g) : (g - r);
    rb   = (r >= b) ? (r - b) : (b - r);
    near = (rg < 8'd15) && (rb < 8'd15);
    if (r > 8'd220 && g > 8'd220 && b > 8'd220) cls = CLS_WHITE;
    else if (r < 8'd35 && g < 8'd35 && b < 8'd35) cls = CLS_BLACK;
    else if (near && r > 8'd170) cls = CLS_SILVER;
    else if (near) cls = CLS_GRAY;
    else if (r > 8'd190 && g < 8'd80 && b < 8'd80) cls = CLS_RED;
    else if (r > 8'd120 && g < 8'd40 && b < 8'd40) cls = CLS_MAROON;
    else if (r > 8'd200 && g > 8'd110 && g < 8'd190 && b < 8'd70) cls = CLS_ORANGE;
    else if (r > 8'd180 && g > 8'd150 && b < 8'd70) cls = CLS_GOLD;
    else if (r > 8'd190 && g > 8'd190 && b < 8'd90) cls = CLS_YELLOW;
    else if (g > 8'd220 && r > 8'd170 && b < 8'd90) cls = CLS_LIME;
    else if (g > 8'd180 && r < 8'd130 && b < 8'd130) cls = CLS_GREEN;
    else if (g > 8'd100 && r < 8'd80 && b < 8'd80) cls = CLS_DARK_GREEN;
    else if (g > 8'd170 && b > 8'd170 && r < 8'd120) cls = CLS_CYAN;
    else if (b > 8'd190 && g > 8'd150 && r < 8'd130) cls = CLS_SKY_BLUE;
    else if (b > 8'd180 && r < 8'd130 && g < 8'd130) cls = CLS_BLUE;
    else if (b > 8'd100 && r < 8'd60 && g < 8'd60) cls = CLS_NAVY;
    else if (r > 8'd150 && b > 8'd150 && g < 8'd100) cls = CLS_PURPLE;
    else if (r > 8'd180 && b > 8'd180 && g < 8'd120) cls = CLS_VIOLET;
    else if (r > 8'd220 && b > 8'd170 && g > 8'd120) cls = CLS_PINK;
    else if (r > 8'd100 && r < 8'd180 && g > 8'd50 && g < 8'd120 && b < 8'd70)
      cls = CLS_BROWN;
    else if (r > 8'd120 && g > 8'd60 && g < 8'd90 && b < 8'd50) cls = CLS_CHOCOLATE;
    else if (r > 8'd190 && g > 8'd180 && b > 8'd120) cls = CLS_BEIGE;
    else if (r > 8'd170 && g > 8'd130 && b > 8'd80) cls = CLS_TAN;
    else if (r > 8'd100 && g > 8'd100 && b < 8'd60) cls = CLS_OLIVE;
    else if (g > 8'd120 && b > 8'd120 && r < 8'd80) cls = CLS_TEAL;
    else if (r > 8'd180 && b > 8'd200 && g > 8'd150) cls = CLS_LAVENDER;
    else if (r > 8'd220 && g > 8'd120 && b > 8'd100) cls = CLS_CORAL;
    else cls = CLS_UNKNOWN;
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/color_sensor_conditioner_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// color_sensor_conditioner_classifier_unit
// Maps pulse widths to levels, averages a batch, smooths, packs and classifies.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  csc_in_t (three pulse widths)
//  out_      output     out_valid/out_stall  csc_out_t (levels, RGB565, classes)
//  cfg_      input      cfg_wr_en            cfg_wr_data (stability threshold)
//
//  One request is taken per cycle while in_stall is low. Six register
//  stages: input, level divide, batch sum, average, smoother, result.
//  A result follows the request that closes a batch of SAMPLES; other
//  requests give no result. Reset is synchronous; there is no clearing pass.
//  A stall on out_ ripples back only through stages that hold an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_sensor_conditioner_classifier_unit #(
  parameter int SAMPLES = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire csc_pkg::csc_in_t   in_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [3:0]         cfg_wr_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output csc_pkg::csc_out_t       out_data
);

  localparam int IDX_W   = $clog2(SAMPLES + 1);
  localparam int SUM_W   = 18 + $clog2(SAMPLES + 1);
  localparam int LIM     = 256 * SAMPLES;
  localparam int X_W     = $clog2(LIM);
  localparam int AVG_SH  = 21;
  localparam int RECIP_W = 22;
  localparam int PROD3_W = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << AVG_SH) + SAMPLES - 1) / SAMPLES);
  localparam int DSH = csc_pkg::DIV5_SHIFT;

  // Handshake and stage valids.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_out;

  // Stage payloads.
  logic [15:0]      pulse0_r [3];
  logic [16:0]      q1_r     [3];
  logic [2:0]       neg1_r;
  logic [SUM_W-1:0] sum2_r   [3];
  logic [7:0]       avg3_r   [3];
  logic [7:0]       lv4_r    [3];
  csc_pkg::csc_out_t out_r;

  // Running state.
  logic [3:0]       thr_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] acc_r    [3];
  logic [15:0]      smooth_r [3];
  logic [4:0]       acc_cls_r;
  logic [3:0]       diff_r;

  // Combinational terms.
  logic [2:0]         neg0;
  logic [15:0]        absd0    [3];
  logic [23:0]        n255     [3];
  logic [37:0]        prod1    [3];
  logic [SUM_W-1:0]   lvl1     [3];
  logic [SUM_W-1:0]   sum_nxt  [3];
  logic               last;
  logic [PROD3_W-1:0] prod3    [3];
  logic [7:0]         avg_nxt  [3];
  logic [18:0]        num3     [3];
  logic [37:0]        prod4    [3];
  logic [15:0]        smooth_nxt [3];
  logic [4:0]         cls_nxt;
  logic [3:0]         diff_inc;
  logic [3:0]         diff_nxt;
  logic [4:0]         acc_cls_nxt;
  csc_pkg::csc_out_t  out_nxt;

  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy4    = !v4_r || rdy_out;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;

  assign in_stall  = !rdy0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign last = (idx_r == IDX_W'(SAMPLES - 1));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // |x - 20| * 255, then / 32 and / 5 to divide by 160.
      neg0[c]  = pulse0_r[c] < csc_pkg::PULSE_OFS;
      absd0[c] = neg0[c] ? (csc_pkg::PULSE_OFS - pulse0_r[c])
                         : (pulse0_r[c] - csc_pkg::PULSE_OFS);
      n255[c]  = {absd0[c], 8'b0} - {8'b0, absd0[c]};
      prod1[c] = {19'b0, n255[c][23:5]} * {19'b0, csc_pkg::DIV5_MUL};

      // Truncation toward zero: the quotient magnitude takes the sign of the offset.
      lvl1[c] = neg1_r[c] ? (SUM_W'(csc_pkg::LEVEL_TOP) + SUM_W'(q1_r[c]))
                          : (SUM_W'(csc_pkg::LEVEL_TOP) - SUM_W'(q1_r[c]));
      sum_nxt[c] = acc_r[c] + lvl1[c];

      // A negative sum averages to zero or below; a sum at or above 256 * SAMPLES
      // clamps to 255. Only the remaining range needs the reciprocal.
      prod3[c] = PROD3_W'(sum2_r[c][X_W-1:0]) * PROD3_W'(RECIP);
      if (sum2_r[c][SUM_W-1]) begin
        avg_nxt[c] = 8'd0;
      end else if (sum2_r[c] >= SUM_W'(LIM)) begin
        avg_nxt[c] = 8'hFF;
      end else begin
        avg_nxt[c] = prod3[c][AVG_SH+7:AVG_SH];
      end

      num3[c]       = {1'b0, smooth_r[c], 2'b00} + {3'b0, avg3_r[c], 8'b0};
      prod4[c]      = {19'b0, num3[c]} * {19'b0, csc_pkg::DIV5_MUL};
      smooth_nxt[c] = prod4[c][DSH+15:DSH];
    end
  end

  always_comb begin
    cls_nxt  = csc_pkg::classify(lv4_r[0], lv4_r[1], lv4_r[2]);
    diff_inc = diff_r + 4'd1;
    if (cls_nxt == acc_cls_r) begin
      diff_nxt    = 4'd0;
      acc_cls_nxt = acc_cls_r;
    end else if (diff_inc >= thr_r) begin
      diff_nxt    = 4'd0;
      acc_cls_nxt = cls_nxt;
    end else begin
      diff_nxt    = diff_inc;
      acc_cls_nxt = acc_cls_r;
    end
    out_nxt.red_level    = lv4_r[0];
    out_nxt.green_level  = lv4_r[1];
    out_nxt.blue_level   = lv4_r[2];
    out_nxt.packed_565   = {lv4_r[0][7:3], lv4_r[1][7:2], lv4_r[2][7:3]};
    out_nxt.color_class  = cls_nxt;
    out_nxt.stable_class = acc_cls_nxt;
  end

  // Control and running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= csc_pkg::THRESH_RESET;
      idx_r       <= '0;
      acc_cls_r   <= csc_pkg::CLS_UNKNOWN;
      diff_r      <= 4'd0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c]    <= '0;
        smooth_r[c] <= 16'd0;
      end
    end else begin
      if (rdy0)    v0_r        <= in_valid;
      if (rdy1)    v1_r        <= v0_r;
      if (rdy2)    v2_r        <= v1_r && last;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy_out) out_valid_r <= v4_r;

      if (cfg_wr_en) thr_r <= cfg_wr_data;

      if (v1_r && rdy2) begin
        idx_r <= last ? '0 : idx_r + IDX_W'(1);
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= last ? '0 : sum_nxt[c];
        end
      end

      if (v3_r && rdy4) begin
        for (int c = 0; c < 3; c++) begin
          smooth_r[c] <= smooth_nxt[c];
        end
      end

      if (v4_r && rdy_out) begin
        acc_cls_r <= acc_cls_nxt;
        diff_r    <= diff_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      pulse0_r[0] <= in_data.red_pulse;
      pulse0_r[1] <= in_data.green_pulse;
      pulse0_r[2] <= in_data.blue_pulse;
    end
    if (v0_r && rdy1) begin
      for (int c = 0; c < 3; c++) begin
        q1_r[c]   <= prod1[c][DSH+16:DSH];
        neg1_r[c] <= neg0[c];
      end
    end
    if (v1_r && rdy2 && last) begin
      for (int c = 0; c < 3; c++) begin
        sum2_r[c] <= sum_nxt[c];
      end
    end
    if (v2_r && rdy3) begin
      for (int c = 0; c < 3; c++) begin
        avg3_r[c] <= avg_nxt[c];
      end
    end
    if (v3_r && rdy4) begin
      for (int c = 0; c < 3; c++) begin
        lv4_r[c] <= smooth_nxt[c][15:8];
      end
    end
    if (v4_r && rdy_out) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csc_checker.sv -----
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks on the color sensor conditioner result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module csc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire csc_pkg::csc_out_t out_data
);

  // A stalled result must hold.
  `CSC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // The RGB565 word must be built from the reported levels.
  `CSC_ASSERT(a_pack_match, clk, rst_n, out_valid |-> (out_data.packed_565[15:11] == out_data.red_level[7:3]) && (out_data.packed_565[10:5] == out_data.green_level[7:2]) && (out_data.packed_565[4:0] == out_data.blue_level[7:3]), "packed word does not match levels")

  // Class codes stay within the rule chain plus unknown.
  `CSC_ASSERT(a_class_range, clk, rst_n, out_valid |-> (out_data.color_class <= csc_pkg::CLS_UNKNOWN) && (out_data.stable_class <= csc_pkg::CLS_UNKNOWN), "class code out of range")

  // Reset empties the result register.
  `CSC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind color_sensor_conditioner_classifier_unit csc_checker u_csc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/color_sensor_conditioner_classifier_unit_tb.sv -----
// ----------------------------------------------------------------------------
// color_sensor_conditioner_classifier_unit_tb
// Drives pulse-width requests through the conditioner and checks every result
// against a table entry or a cycle-free predictor of the batch average, the
// Q8.8 smoother, the RGB565 pack, the color rule chain and the class debounce.
// A short directed table comes first, then randomized batches under several
// idle patterns and stability thresholds, including a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_sensor_conditioner_classifier_unit_tb;

  localparam int SAMPLES = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    csc_pkg::csc_in_t  pulses;
    logic              known;
    csc_pkg::csc_out_t result;
  } directed_row_t;

  // The first batch maps every pulse to a level at or below zero, the second to
  // a level at or above full scale. Only the batch-closing rows carry a result.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{16'h8000, 16'h4000, 16'h2000}, 1'b0, '0},
    '{'{16'h1000, 16'h0800, 16'h0400}, 1'b0, '0},
    '{'{16'h0200, 16'h0100, 16'h00B4}, 1'b0, '0},
    '{'{16'h00B5, 16'h00B4, 16'hFFFF}, 1'b0, '0},
    '{'{16'hAAAA, 16'h5555, 16'h00FF}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'h7FFF}, 1'b0, '0},
    '{'{16'h00B4, 16'h00B4, 16'h00B4}, 1'b0, '0},
    '{'{16'hFFFE, 16'hFFFD, 16'h0180}, 1'b0, '0},
    '{'{16'h00C8, 16'h00D0, 16'h00E0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 16'h0000, csc_pkg::CLS_BLACK, csc_pkg::CLS_UNKNOWN}},
    '{'{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h0001, 16'h0002, 16'h0004}, 1'b0, '0},
    '{'{16'h0008, 16'h0010, 16'h0014}, 1'b0, '0},
    '{'{16'h0014, 16'h0014, 16'h0014}, 1'b0, '0},
    '{'{16'h0003, 16'h0005, 16'h0006}, 1'b0, '0},
    '{'{16'h0007, 16'h0009, 16'h000A}, 1'b0, '0},
    '{'{16'h000B, 16'h000C, 16'h000D}, 1'b0, '0},
    '{'{16'h000E, 16'h000F, 16'h0011}, 1'b0, '0},
    '{'{16'h0012, 16'h0013, 16'h0000}, 1'b0, '0},
    '{'{16'h0014, 16'h0000, 16'h0001}, 1'b1,
      '{8'd51, 8'd51, 8'd51, 16'h3186, csc_pkg::CLS_GRAY, csc_pkg::CLS_UNKNOWN}},
    '{'{16'h0064, 16'h0032, 16'h0096}, 1'b0, '0},
    '{'{16'h0050, 16'h00A0, 16'h0020}, 1'b0, '0},
    '{'{16'h0100, 16'h0019, 16'h0040}, 1'b0, '0},
    '{'{16'h0028, 16'h0078, 16'h00AA}, 1'b0, '0},
    '{'{16'h003C, 16'h008C, 16'h0015}, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  csc_pkg::csc_in_t  in_data;
  logic              cfg_wr_en;
  logic [3:0]        cfg_wr_data;
  logic              out_valid;
  logic              out_stall;
  csc_pkg::csc_out_t out_data;

  // Predictor state.
  int          batch_fill;
  longint      level_sum [3];
  logic [15:0] smooth_q88 [3];
  logic [4:0]  held_class;
  logic [3:0]  differ_run;
  logic [3:0]  threshold;

  csc_pkg::csc_out_t pending_results [$];
  int                errors;

  // Typed expectation for the request currently offered, if any.
  logic              pin_known;
  csc_pkg::csc_out_t pin_result;

  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          hold_req;

  color_sensor_conditioner_classifier_unit #(
    .SAMPLES(SAMPLES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint pulse_level(input logic [15:0] x);
    longint d;
    d = longint'(x) - 20;
    return (d * -255) / 160 + 255;
  endfunction

  function automatic logic [4:0] color_rule(input int r, input int g, input int b);
    int  dg;
    int  db;
    bit  close;
    dg = (r > g) ? r - g : g - r;
    db = (r > b) ? r - b : b - r;
    close = (dg < 15) && (db < 15);
    if (r > 220 && g > 220 && b > 220) return csc_pkg::CLS_WHITE;
    if (r < 35 && g < 35 && b < 35) return csc_pkg::CLS_BLACK;
    if (close && r > 170) return csc_pkg::CLS_SILVER;
    if (close) return csc_pkg::CLS_GRAY;
    if (r > 190 && g < 80 && b < 80) return csc_pkg::CLS_RED;
    if (r > 120 && g < 40 && b < 40) return csc_pkg::CLS_MAROON;
    if (r > 200 && g > 110 && g < 190 && b < 70) return csc_pkg::CLS_ORANGE;
    if (r > 180 && g > 150 && b < 70) return csc_pkg::CLS_GOLD;
    if (r > 190 && g > 190 && b < 90) return csc_pkg::CLS_YELLOW;
    if (g > 220 && r > 170 && b < 90) return csc_pkg::CLS_LIME;
    if (g > 180 && r < 130 && b < 130) return csc_pkg::CLS_GREEN;
    if (g > 100 && r < 80 && b < 80) return csc_pkg::CLS_DARK_GREEN;
    if (g > 170 && b > 170 && r < 120) return csc_pkg::CLS_CYAN;
    if (b > 190 && g > 150 && r < 130) return csc_pkg::CLS_SKY_BLUE;
    if (b > 180 && r < 130 && g < 130) return csc_pkg::CLS_BLUE;
    if (b > 100 && r < 60 && g < 60) return csc_pkg::CLS_NAVY;
    if (r > 150 && b > 150 && g < 100) return csc_pkg::CLS_PURPLE;
    if (r > 180 && b > 180 && g < 120) return csc_pkg::CLS_VIOLET;
    if (r > 220 && b > 170 && g > 120) return csc_pkg::CLS_PINK;
    if (r > 100 && r < 180 && g > 50 && g < 120 && b < 70) return csc_pkg::CLS_BROWN;
    if (r > 120 && g > 60 && g < 90 && b < 50) return csc_pkg::CLS_CHOCOLATE;
    if (r > 190 && g > 180 && b > 120) return csc_pkg::CLS_BEIGE;
    if (r > 170 && g > 130 && b > 80) return csc_pkg::CLS_TAN;
    if (r > 100 && g > 100 && b < 60) return csc_pkg::CLS_OLIVE;
    if (g > 120 && b > 120 && r < 80) return csc_pkg::CLS_TEAL;
    if (r > 180 && b > 200 && g > 150) return csc_pkg::CLS_LAVENDER;
    if (r > 220 && g > 120 && b > 100) return csc_pkg::CLS_CORAL;
    return csc_pkg::CLS_UNKNOWN;
  endfunction

  // Folds one request into the batch; closed is set when the batch completes.
  task automatic fold_pulses(input csc_pkg::csc_in_t s, output bit closed,
                             output csc_pkg::csc_out_t res);
    logic [15:0] p [3];
    logic [7:0]  lv [3];
    longint      avg;
    int          next_q;
    logic [4:0]  cls;
    p = '{s.red_pulse, s.green_pulse, s.blue_pulse};
    closed = 1'b0;
    res = '0;
    for (int ch = 0; ch < 3; ch++) level_sum[ch] += pulse_level(p[ch]);
    batch_fill++;
    if (batch_fill < SAMPLES) return;
    batch_fill = 0;
    closed = 1'b1;
    for (int ch = 0; ch < 3; ch++) begin
      avg = level_sum[ch] / SAMPLES;
      if (avg < 0) avg = 0;
      if (avg > 255) avg = 255;
      next_q = (4 * int'(smooth_q88[ch]) + 256 * int'(avg)) / 5;
      smooth_q88[ch] = next_q[15:0];
      lv[ch] = smooth_q88[ch][15:8];
      level_sum[ch] = 0;
    end
    cls = color_rule(lv[0], lv[1], lv[2]);
    if (cls == held_class) begin
      differ_run = '0;
    end else begin
      differ_run = differ_run + 4'd1;
      if (differ_run >= threshold) begin
        held_class = cls;
        differ_run = '0;
      end
    end
    res.red_level    = lv[0];
    res.green_level  = lv[1];
    res.blue_level   = lv[2];
    res.packed_565   = {lv[0][7:3], lv[1][7:2], lv[2][7:3]};
    res.color_class  = cls;
    res.stable_class = held_class;
  endtask

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    csc_pkg::csc_out_t predicted;
    bit                closed;
    if (!rst_n) begin
      batch_fill = 0;
      for (int ch = 0; ch < 3; ch++) begin
        level_sum[ch] = 0;
        smooth_q88[ch] = '0;
      end
      held_class = csc_pkg::CLS_UNKNOWN;
      differ_run = '0;
      threshold = csc_pkg::THRESH_RESET;
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_valid && !in_stall) begin
        fold_pulses(in_data, closed, predicted);
        if (closed) pending_results.push_back(pin_known ? pin_result : predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          predicted = pending_results.pop_front();
          report_field("red_level", predicted.red_level, out_data.red_level);
          report_field("green_level", predicted.green_level, out_data.green_level);
          report_field("blue_level", predicted.blue_level, out_data.blue_level);
          report_field("packed_565", predicted.packed_565, out_data.packed_565);
          report_field("color_class", predicted.color_class, out_data.color_class);
          report_field("stable_class", predicted.stable_class, out_data.stable_class);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when the driver asks.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (receiver_idle_pct > 0) && ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("color_sensor_conditioner_classifier_unit verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(input csc_pkg::csc_in_t d, input logic known,
                              input csc_pkg::csc_out_t res);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_known = known;
    pin_result = res;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input logic [3:0] thr, input bit squeeze);
    int          sent;
    int          hold;
    int          kind;
    int          p;
    int          target [3];
    logic [15:0] f [3];
    wait_idle();
    sender_idle_pct = tx_pct;
    receiver_idle_pct = rx_pct;
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= thr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sent = 0;
    hold = 0;
    while (sent < n_items) begin
      // A color is held over 1 to 12 batches so the smoother settles on it.
      if (hold == 0) begin
        hold = $urandom_range(1, 12);
        for (int ch = 0; ch < 3; ch++) begin
          case ($urandom_range(2))
            0: target[ch] = $urandom_range(0, 60);
            1: target[ch] = $urandom_range(61, 190);
            default: target[ch] = $urandom_range(191, 255);
          endcase
        end
      end
      hold--;
      kind = $urandom_range(99);
      for (int k = 0; k < SAMPLES && sent < n_items; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          if (kind < 70) begin
            p = 20 + (255 - target[ch]) * 160 / 255 + int'($urandom_range(6)) - 3;
            if (p < 0) p = 0;
            f[ch] = p[15:0];
          end else if (kind < 85) begin
            f[ch] = 16'($urandom);
          end else begin
            case ($urandom_range(3))
              0: f[ch] = 16'h0000;
              1: f[ch] = 16'hFFFF;
              2: f[ch] = 16'($urandom_range(20));
              default: f[ch] = 16'($urandom_range(180, 65535));
            endcase
          end
        end
        if (squeeze && sent == n_items / 2) hold_req = 1'b1;
        push_request('{f[0], f[1], f[2]}, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : driver
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = csc_pkg::THRESH_RESET;
    pin_known = 1'b0;
    pin_result = '0;
    hold_req = 1'b0;
    errors = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 29;
    receiver_idle_pct = 48;
    foreach (DIRECTED_ROWS[i])
      push_request(DIRECTED_ROWS[i].pulses, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
    in_valid <= 1'b0;

    // A threshold of zero must act like one: any new class is taken at once.
    run_phase(300, 29, 48, 4'd15, 1'b0);
    run_phase(300, 48, 29, 4'd0, 1'b0);
    run_phase(200, 0, 0, 4'd1, 1'b0);
    run_phase(100, 0, 0, 4'($urandom_range(2, 14)), 1'b1);

    wait_idle();
    if (errors == 0) begin
      $display("color_sensor_conditioner_classifier_unit verification clean");
    end else begin
      $display("color_sensor_conditioner_classifier_unit verification failed");
    end
    $finish;
  end

endmodule
